// File: rtl/tpq_pkg.sv
// Shared types, sizes and codes of the timestamp priority queue.
package tpq_pkg;

  localparam int CAPACITY    = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int COUNT_OUT_W = 6;
  localparam int KEY_W       = 38;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_POPPED  = 2'd0,
    ST_LISTED  = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_DROPPED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SRC_HEAD  = 2'd0,
    SRC_INPUT = 2'd1,
    SRC_ZERO  = 2'd2
  } src_e;

  // Controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    insert;
    logic    pop;
    logic    rotate;
    logic    idx_clr;
    logic    emit;
    src_e    emit_src;
    status_e emit_status;
    logic    emit_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       empty;
    logic       full;
    logic       out_free;
    logic       list_last;
  } dp_stat_t;

  function automatic logic [KEY_W-1:0] key_of(entry_t e);
    key_of = {e.year, e.month, e.day, e.hour, e.minute, e.second};
  endfunction

endpackage

// File: rtl/tpq_in_if.sv
// Command channel of the timestamp priority queue.
interface tpq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] stamp_year;
  logic [3:0]  stamp_month;
  logic [4:0]  stamp_day;
  logic [4:0]  stamp_hour;
  logic [5:0]  stamp_minute;
  logic [5:0]  stamp_second;
  logic [15:0] event_tag;

  modport source (
    output valid, command, stamp_year, stamp_month, stamp_day, stamp_hour,
           stamp_minute, stamp_second, event_tag,
    input  ready
  );
  modport sink (
    input  valid, command, stamp_year, stamp_month, stamp_day, stamp_hour,
           stamp_minute, stamp_second, event_tag,
    output ready
  );
endinterface

// File: rtl/tpq_out_if.sv
// Result channel of the timestamp priority queue.
interface tpq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [15:0] out_tag;
  logic [5:0]  entry_count;
  logic        last;

  modport source (
    output valid, status, out_year, out_month, out_day, out_hour, out_minute,
           out_second, out_tag, entry_count, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_year, out_month, out_day, out_hour, out_minute,
           out_second, out_tag, entry_count, last,
    output ready
  );
endinterface

// File: rtl/tpq_dp.sv
// Datapath: sorted cell chain, entry count, list index and result register.
module tpq_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tpq_pkg::dp_cmd_t           cmd_i,
  input  logic [1:0]                 in_cmd_i,
  input  tpq_pkg::entry_t            in_entry_i,
  input  logic                       out_ready_i,
  output tpq_pkg::dp_stat_t          stat_o,
  output logic                       out_valid_o,
  output tpq_pkg::status_e           out_status_o,
  output tpq_pkg::entry_t            out_entry_o,
  output logic [tpq_pkg::COUNT_OUT_W-1:0] out_count_o,
  output logic                       out_last_o
);

  localparam int CAP   = tpq_pkg::CAPACITY;
  localparam int CNT_W = tpq_pkg::CNT_W;
  localparam int IDX_W = tpq_pkg::IDX_W;

  tpq_pkg::entry_t cell_q [CAP];
  tpq_pkg::entry_t cell_d [CAP];
  tpq_pkg::entry_t in_q;
  logic [1:0]      cmd_q;
  logic [CNT_W-1:0] count_q, count_d, count_m1;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CAP-1:0]   gt;

  logic                     out_valid_q;
  tpq_pkg::status_e         out_status_q;
  tpq_pkg::entry_t          out_entry_q;
  logic [tpq_pkg::COUNT_OUT_W-1:0] out_count_q;
  logic                     out_last_q;
  tpq_pkg::entry_t          emit_entry;

  assign count_m1 = count_q - CNT_W'(1);

  // A cell moves when it is empty or later than the new word: ties stay ahead.
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      gt[i] = (CNT_W'(i) >= count_q) ||
              (tpq_pkg::key_of(cell_q[i]) > tpq_pkg::key_of(in_q));
    end
  end

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      cell_d[i] = cell_q[i];
    end
    if (cmd_i.insert) begin
      if (gt[0]) cell_d[0] = in_q;
      for (int i = 1; i < CAP; i++) begin
        if (gt[i]) cell_d[i] = gt[i-1] ? cell_q[i-1] : in_q;
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < CAP - 1; i++) begin
        cell_d[i] = cell_q[i+1];
      end
    end else if (cmd_i.rotate) begin
      // Advance the chain and wrap the head to the tail of the held run.
      for (int i = 0; i < CAP - 1; i++) begin
        cell_d[i] = (CNT_W'(i) == count_m1) ? cell_q[0] : cell_q[i+1];
      end
      if (count_q == CNT_W'(CAP)) cell_d[CAP-1] = cell_q[0];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) count_d = count_q + CNT_W'(1);
    else if (cmd_i.pop) count_d = count_m1;
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) idx_d = '0;
    else if (cmd_i.rotate) idx_d = idx_q + IDX_W'(1);
  end

  always_comb begin
    unique case (cmd_i.emit_src)
      tpq_pkg::SRC_HEAD:  emit_entry = cell_q[0];
      tpq_pkg::SRC_INPUT: emit_entry = in_q;
      default:            emit_entry = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAP; i++) begin
      cell_q[i] <= cell_d[i];
    end
    if (cmd_i.load_in) begin
      in_q  <= in_entry_i;
      cmd_q <= in_cmd_i;
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.emit_status;
      out_entry_q  <= emit_entry;
      out_count_q  <= tpq_pkg::COUNT_OUT_W'(count_d);
      out_last_q   <= cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q >= CNT_W'(CAP));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.list_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_entry_o  = out_entry_q;
  assign out_count_o  = out_count_q;
  assign out_last_o   = out_last_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAP))
    else $error("entry count above capacity");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten while held");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> (count_q < CNT_W'(CAP)))
    else $error("insert into full chain");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("pop did not drop the count by one");

endmodule

// File: rtl/tpq_ctrl.sv
// Controller: sequences insert, pop and list commands over the datapath.
module tpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tpq_pkg::dp_stat_t stat_i,
  output tpq_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LIST = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.emit_src     = tpq_pkg::SRC_HEAD;
    cmd_o.emit_status  = tpq_pkg::ST_POPPED;
    in_ready_o         = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat_i.cmd)
          tpq_pkg::CMD_INSERT: begin
            if (!stat_i.full) begin
              cmd_o.insert = 1'b1;
              state_d      = S_IDLE;
            end else if (stat_i.out_free) begin
              // Drop the word and echo it back
              cmd_o.emit        = 1'b1;
              cmd_o.emit_src    = tpq_pkg::SRC_INPUT;
              cmd_o.emit_status = tpq_pkg::ST_DROPPED;
              cmd_o.emit_last   = 1'b1;
              state_d           = S_IDLE;
            end
          end
          tpq_pkg::CMD_POP: begin
            if (stat_i.empty) begin
              state_d = S_IDLE;
            end else if (stat_i.out_free) begin
              cmd_o.pop         = 1'b1;
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = tpq_pkg::ST_POPPED;
              cmd_o.emit_last   = 1'b1;
              state_d           = S_IDLE;
            end
          end
          tpq_pkg::CMD_LIST: begin
            if (!stat_i.empty) begin
              cmd_o.idx_clr = 1'b1;
              state_d       = S_LIST;
            end else if (stat_i.out_free) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_src    = tpq_pkg::SRC_ZERO;
              cmd_o.emit_status = tpq_pkg::ST_EMPTY;
              cmd_o.emit_last   = 1'b1;
              state_d           = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_LIST: begin
        // One word per free slot; a full turn of the chain restores the order.
        if (stat_i.out_free) begin
          cmd_o.rotate      = 1'b1;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = tpq_pkg::ST_LISTED;
          cmd_o.emit_last   = stat_i.list_last;
          if (stat_i.list_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.insert, cmd_o.pop, cmd_o.rotate}))
    else $error("more than one chain move in a cycle");

  a_list_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST && cmd_o.emit && stat_i.list_last) |=> (state_q == S_IDLE))
    else $error("list run did not end on its last word");

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_in |=> (state_q == S_EXEC))
    else $error("accepted word not executed");

endmodule

// File: rtl/timestamp_priority_queue.sv
// Top level of the timestamp priority queue.
//
// Usage: commands arrive on in_i (valid/ready); a word is taken at a clock
// edge with valid and ready both high. Insert (0) files the entry after every
// held entry of equal or earlier time, pop (1) returns and removes the earliest,
// list (2) returns every held entry in order with the count, last on the final
// word. Results leave on out_o (valid/ready) from one output register.
// Timing: ready is high only while the sequencer is idle, so a command is
// not taken until the one before it is through. An insert, an empty pop or an
// unused code completes in the execute state, then ready returns. A pop, a
// dropped insert or an empty list loads its result word in the execute state
// once the output register is free, then ready returns. A list clears its
// index in the execute state, then loads one word per cycle while the output
// register is free. Each command is registered before the chain acts on it.
// Reset: the entry count and the sequencer clear at once; stored entries are
// not cleared and are never read before being written.
// Stall: while out_o.ready is low the result word holds and a command that must
// emit waits, so no word is lost and the chain does not move for it.
module timestamp_priority_queue (
  input  logic clk_i,
  input  logic rst_ni,
  tpq_in_if.sink    in_i,
  tpq_out_if.source out_o
);

  tpq_pkg::dp_cmd_t  dp_cmd;
  tpq_pkg::dp_stat_t dp_stat;
  tpq_pkg::entry_t   in_entry;
  tpq_pkg::entry_t   out_entry;
  tpq_pkg::status_e  out_status;
  logic              in_ready;

  assign in_entry.year   = in_i.stamp_year;
  assign in_entry.month  = in_i.stamp_month;
  assign in_entry.day    = in_i.stamp_day;
  assign in_entry.hour   = in_i.stamp_hour;
  assign in_entry.minute = in_i.stamp_minute;
  assign in_entry.second = in_i.stamp_second;
  assign in_entry.tag    = in_i.event_tag;
  assign in_i.ready      = in_ready;

  tpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  tpq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .in_cmd_i     (in_i.command),
    .in_entry_i   (in_entry),
    .out_ready_i  (out_o.ready),
    .stat_o       (dp_stat),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_status),
    .out_entry_o  (out_entry),
    .out_count_o  (out_o.entry_count),
    .out_last_o   (out_o.last)
  );

  assign out_o.status     = out_status;
  assign out_o.out_year   = out_entry.year;
  assign out_o.out_month  = out_entry.month;
  assign out_o.out_day    = out_entry.day;
  assign out_o.out_hour   = out_entry.hour;
  assign out_o.out_minute = out_entry.minute;
  assign out_o.out_second = out_entry.second;
  assign out_o.out_tag    = out_entry.tag;

endmodule
